// File: src/jbt_pkg.sv
// shared types, character codes and keyword tables for the json byte tokenizer
`default_nettype none

package jbt_pkg;

   // widths of the depth counters and the line and column counters
   localparam int DEPTH_WIDTH    = 16;
   localparam int POSITION_WIDTH = 20;

   localparam logic [DEPTH_WIDTH-1:0]    DEPTH_MAX = {DEPTH_WIDTH{1'b1}};
   localparam logic [POSITION_WIDTH-1:0] POS_MAX   = {POSITION_WIDTH{1'b1}};
   localparam logic [POSITION_WIDTH-1:0] POS_ONE   = POSITION_WIDTH'(1);

   // character codes
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_POINT    = 8'h2E;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_A        = 8'h61;
   localparam logic [7:0] CH_E        = 8'h65;
   localparam logic [7:0] CH_F        = 8'h66;
   localparam logic [7:0] CH_L        = 8'h6C;
   localparam logic [7:0] CH_N        = 8'h6E;
   localparam logic [7:0] CH_R        = 8'h72;
   localparam logic [7:0] CH_S        = 8'h73;
   localparam logic [7:0] CH_T        = 8'h74;
   localparam logic [7:0] CH_U        = 8'h75;

   typedef enum logic [1:0] {
      MODE_GAP,
      MODE_STRING,
      MODE_NUMBER,
      MODE_KEYWORD
   } mode_type;

   typedef enum logic [3:0] {
      KIND_BLANK,
      KIND_OPEN_BRACE,
      KIND_CLOSE_BRACE,
      KIND_OPEN_BRACKET,
      KIND_CLOSE_BRACKET,
      KIND_COMMA,
      KIND_COLON,
      KIND_STRING,
      KIND_NUMBER,
      KIND_TRUE,
      KIND_FALSE,
      KIND_NULL
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE,
      ERR_BAD_CHAR,
      ERR_BAD_KEYWORD,
      ERR_BAD_START,
      ERR_NEWLINE_IN_STRING,
      ERR_OPEN_STRING,
      ERR_LEADING_ZERO,
      ERR_REPEATED_MINUS,
      ERR_REPEATED_POINT,
      ERR_BRACKETS,
      ERR_BRACES,
      ERR_AFTER_ROOT,
      ERR_DEPTH_OVERFLOW
   } err_type;

   // keyword selector: true, false, null (the fourth code reads as null)
   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   typedef struct packed {
      mode_type                  mode;
      logic [1:0]                kw_kind;
      logic [2:0]                kw_pos;
      logic                      num_minus;
      logic                      num_point;
      logic                      num_zero;
      logic                      root_seen;
      logic                      root_is_bracket;
      logic                      root_closed;
      logic [DEPTH_WIDTH-1:0]    brace_depth;
      logic [DEPTH_WIDTH-1:0]    bracket_depth;
      logic [POSITION_WIDTH-1:0] line;
      logic [POSITION_WIDTH-1:0] column;
      logic [POSITION_WIDTH-1:0] start_line;
      logic [POSITION_WIDTH-1:0] start_column;
      err_type                   error;
   } scan_state_type;

   typedef struct packed {
      kind_type                  token_kind;
      logic                      token_first;
      logic                      token_final;
      logic                      number_closed;
      logic [POSITION_WIDTH-1:0] token_line;
      logic [POSITION_WIDTH-1:0] token_column;
      err_type                   error_code;
      logic                      result_last;
   } rsp_data_type;

   localparam scan_state_type SCAN_RESET = '{
      mode:            MODE_GAP,
      kw_kind:         2'd0,
      kw_pos:          3'd0,
      num_minus:       1'b0,
      num_point:       1'b0,
      num_zero:        1'b0,
      root_seen:       1'b0,
      root_is_bracket: 1'b0,
      root_closed:     1'b0,
      brace_depth:     '0,
      bracket_depth:   '0,
      line:            POS_ONE,
      column:          POS_ONE,
      start_line:      POS_ONE,
      start_column:    POS_ONE,
      error:           ERR_NONE
   };

   // saturating position increment
   function automatic logic [POSITION_WIDTH-1:0] pos_inc(input logic [POSITION_WIDTH-1:0] v);
      pos_inc = (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   // expected letter of a keyword at a position, zero past its end
   function automatic logic [7:0] kw_char(input logic [1:0] kk, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (kk)
         KW_TRUE: begin
            case (pos)
               3'd0:    ch = CH_T;
               3'd1:    ch = CH_R;
               3'd2:    ch = CH_U;
               3'd3:    ch = CH_E;
               default: ch = 8'h00;
            endcase
         end
         KW_FALSE: begin
            case (pos)
               3'd0:    ch = CH_F;
               3'd1:    ch = CH_A;
               3'd2:    ch = CH_L;
               3'd3:    ch = CH_S;
               3'd4:    ch = CH_E;
               default: ch = 8'h00;
            endcase
         end
         default: begin
            case (pos)
               3'd0:    ch = CH_N;
               3'd1:    ch = CH_U;
               3'd2:    ch = CH_L;
               3'd3:    ch = CH_L;
               default: ch = 8'h00;
            endcase
         end
      endcase
      kw_char = ch;
   endfunction

   // keyword length in letters
   function automatic logic [2:0] kw_len(input logic [1:0] kk);
      kw_len = (kk == KW_FALSE) ? 3'd5 : 3'd4;
   endfunction

endpackage

`default_nettype wire

// File: src/jbt_req_if.sv
// request channel: one text byte with its end-of-text flag
`default_nettype none

interface jbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: src/jbt_rsp_if.sv
// response channel: token information for one text byte
`default_nettype none

interface jbt_rsp_if;
   import jbt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [3:0]                token_kind;
   logic                      token_first;
   logic                      token_final;
   logic                      number_closed;
   logic [POSITION_WIDTH-1:0] token_line;
   logic [POSITION_WIDTH-1:0] token_column;
   logic [3:0]                error_code;
   logic                      result_last;

   modport source (
      output valid, output token_kind, output token_first, output token_final,
      output number_closed, output token_line, output token_column,
      output error_code, output result_last, input ready
   );
   modport sink (
      input valid, input token_kind, input token_first, input token_final,
      input number_closed, input token_line, input token_column,
      input error_code, input result_last, output ready
   );
endinterface

`default_nettype wire

// File: src/json_byte_tokenizer.sv
// top level of the json byte tokenizer: request register, scan state, response register
//
// One byte of JSON text is taken per request and yields exactly one response
// carrying its token kind, start and end flags, the position where the current
// token began and the sticky error code; the byte flagged end_of_text closes the
// text and returns all state to reset. A request is held in the request
// register, then the scan-state update and the response are formed
// combinationally and the response is registered; one byte is taken every
// cycle while the response side keeps up. The throughput limit is the single
// scan-state register, which every byte reads and writes once. There is no
// memory and no clearing pass after reset.
`default_nettype none

module json_byte_tokenizer (
   input  logic             clock,
   input  logic             reset,
   jbt_req_if.sink          req_chan,
   jbt_rsp_if.source        rsp_chan
);
   import jbt_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic [7:0]     in_byte_in;
   logic           in_last_ff;
   logic           in_last_in;
   scan_state_type state_ff;
   scan_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_data_type   rsp_data_ff;
   rsp_data_type   rsp_data_in;

   scan_state_type step_state;
   rsp_data_type   step_result;
   logic           advance;
   logic           req_take;

   // scan logic for the byte in the request register
   jbt_step u_step (
      .state       (state_ff),
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .state_next  (step_state),
      .result      (step_result)
   );

   // handshake: a byte moves on when the response register is free or draining
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         state_in     = step_state;
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.text_byte;
         in_last_in  = req_chan.end_of_text;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SCAN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // response port
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.token_kind    = rsp_data_ff.token_kind;
   assign rsp_chan.token_first   = rsp_data_ff.token_first;
   assign rsp_chan.token_final   = rsp_data_ff.token_final;
   assign rsp_chan.number_closed = rsp_data_ff.number_closed;
   assign rsp_chan.token_line    = rsp_data_ff.token_line;
   assign rsp_chan.token_column  = rsp_data_ff.token_column;
   assign rsp_chan.error_code    = rsp_data_ff.error_code;
   assign rsp_chan.result_last   = rsp_data_ff.result_last;

`ifndef NO_ASSERTIONS
   // open nesting only exists once the root has opened
   a_depth_needs_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff.brace_depth != '0 || state_ff.bracket_depth != '0) |-> state_ff.root_seen)
      else $error("nesting depth without a root");

   // a token in progress only exists once the root has opened
   a_mode_needs_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode != MODE_GAP) |-> state_ff.root_seen)
      else $error("token in progress without a root");

   // a stuck error survives every byte but the final one
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.error != ERR_NONE && !in_last_ff)
      |=> (state_ff.error == $past(state_ff.error)))
      else $error("sticky error changed before end of text");

   // the token start never lies past the current line
   a_start_line: assert property (@(posedge clock) disable iff (reset)
      state_ff.start_line <= state_ff.line)
      else $error("token start line beyond current line");

   // requests stall only behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("request stalled without backpressure");
`endif

endmodule

`default_nettype wire

// File: src/jbt_step.sv
// per-byte scanner logic: next scan state and the response for one byte
`default_nettype none

module jbt_step (
   input  jbt_pkg::scan_state_type state,
   input  logic [7:0]              text_byte,
   input  logic                    end_of_text,
   output jbt_pkg::scan_state_type state_next,
   output jbt_pkg::rsp_data_type   result
);
   import jbt_pkg::*;

   scan_state_type nx;
   kind_type       kind;
   kind_type       gap_kind;
   logic           first;
   logic           fin;
   logic           nclosed;
   logic           gap;
   logic           is_digit;
   err_type        err;

   // token kind that a byte opens between tokens, blank if none
   always_comb begin
      case (text_byte) inside
         CH_LBRACE:            gap_kind = KIND_OPEN_BRACE;
         CH_RBRACE:            gap_kind = KIND_CLOSE_BRACE;
         CH_LBRACKET:          gap_kind = KIND_OPEN_BRACKET;
         CH_RBRACKET:          gap_kind = KIND_CLOSE_BRACKET;
         CH_COMMA:             gap_kind = KIND_COMMA;
         CH_COLON:             gap_kind = KIND_COLON;
         CH_QUOTE:             gap_kind = KIND_STRING;
         CH_T:                 gap_kind = KIND_TRUE;
         CH_F:                 gap_kind = KIND_FALSE;
         CH_N:                 gap_kind = KIND_NULL;
         [CH_ZERO:CH_NINE], CH_MINUS: gap_kind = KIND_NUMBER;
         default:              gap_kind = KIND_BLANK;
      endcase
   end

   assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);

   // scanner state update
   always_comb begin
      nx      = state;
      kind    = KIND_BLANK;
      first   = 1'b0;
      fin     = 1'b0;
      nclosed = 1'b0;
      gap     = 1'b0;
      err     = ERR_NONE;

      if (state.error == ERR_NONE) begin
         // continue a multi-byte token
         case (state.mode)
            MODE_STRING: begin
               kind = KIND_STRING;
               if (text_byte == CH_NEWLINE) begin
                  err = ERR_NEWLINE_IN_STRING;
               end else begin
                  if (text_byte == CH_QUOTE) begin
                     fin     = 1'b1;
                     nx.mode = MODE_GAP;
                  end
                  nx.column = pos_inc(state.column);
               end
            end
            MODE_KEYWORD: begin
               if (state.kw_kind == KW_TRUE) begin
                  kind = KIND_TRUE;
               end else if (state.kw_kind == KW_FALSE) begin
                  kind = KIND_FALSE;
               end else begin
                  kind = KIND_NULL;
               end
               if (text_byte != kw_char(state.kw_kind, state.kw_pos)) begin
                  err = ERR_BAD_KEYWORD;
               end else begin
                  nx.kw_pos = state.kw_pos + 3'd1;
                  nx.column = pos_inc(state.column);
                  if ((state.kw_pos + 3'd1) >= kw_len(state.kw_kind)) begin
                     fin     = 1'b1;
                     nx.mode = MODE_GAP;
                  end
               end
            end
            MODE_NUMBER: begin
               if (is_digit || text_byte == CH_MINUS || text_byte == CH_POINT) begin
                  kind = KIND_NUMBER;
                  if (state.num_zero && is_digit) begin
                     err = ERR_LEADING_ZERO;
                  end else if (text_byte == CH_MINUS && state.num_minus) begin
                     err = ERR_REPEATED_MINUS;
                  end else if (text_byte == CH_POINT && state.num_point) begin
                     err = ERR_REPEATED_POINT;
                  end else begin
                     if (text_byte == CH_MINUS) nx.num_minus = 1'b1;
                     if (text_byte == CH_POINT) nx.num_point = 1'b1;
                     nx.num_zero = 1'b0;
                     nx.column   = pos_inc(state.column);
                  end
               end else begin
                  // number ends here, byte handled as between tokens
                  nclosed = 1'b1;
                  nx.mode = MODE_GAP;
                  gap     = 1'b1;
               end
            end
            default: begin
               gap = 1'b1;
            end
         endcase

         // byte between tokens
         if (gap) begin
            nx.start_line   = state.line;
            nx.start_column = state.column;
            if (text_byte == CH_SPACE || text_byte == CH_TAB) begin
               nx.column = pos_inc(state.column);
            end else if (text_byte == CH_NEWLINE) begin
               nx.line   = pos_inc(state.line);
               nx.column = POS_ONE;
            end else if (gap_kind == KIND_BLANK) begin
               err = ERR_BAD_CHAR;
            end else if (state.root_closed) begin
               err = ERR_AFTER_ROOT;
            end else if (!state.root_seen && gap_kind != KIND_OPEN_BRACE &&
                         gap_kind != KIND_OPEN_BRACKET) begin
               err = ERR_BAD_START;
            end else begin
               case (gap_kind)
                  KIND_OPEN_BRACE: begin
                     if (state.brace_depth == DEPTH_MAX) begin
                        err = ERR_DEPTH_OVERFLOW;
                     end else begin
                        nx.brace_depth = state.brace_depth + DEPTH_WIDTH'(1);
                        if (!state.root_seen) begin
                           nx.root_seen       = 1'b1;
                           nx.root_is_bracket = 1'b0;
                        end
                     end
                  end
                  KIND_OPEN_BRACKET: begin
                     if (state.bracket_depth == DEPTH_MAX) begin
                        err = ERR_DEPTH_OVERFLOW;
                     end else begin
                        nx.bracket_depth = state.bracket_depth + DEPTH_WIDTH'(1);
                        if (!state.root_seen) begin
                           nx.root_seen       = 1'b1;
                           nx.root_is_bracket = 1'b1;
                        end
                     end
                  end
                  KIND_CLOSE_BRACE: begin
                     if (state.brace_depth == '0) begin
                        err = ERR_BRACES;
                     end else begin
                        nx.brace_depth = state.brace_depth - DEPTH_WIDTH'(1);
                        if (state.brace_depth == DEPTH_WIDTH'(1) && !state.root_is_bracket) begin
                           nx.root_closed = 1'b1;
                        end
                     end
                  end
                  KIND_CLOSE_BRACKET: begin
                     if (state.bracket_depth == '0) begin
                        err = ERR_BRACKETS;
                     end else begin
                        nx.bracket_depth = state.bracket_depth - DEPTH_WIDTH'(1);
                        if (state.bracket_depth == DEPTH_WIDTH'(1) && state.root_is_bracket) begin
                           nx.root_closed = 1'b1;
                        end
                     end
                  end
                  KIND_STRING: begin
                     nx.mode = MODE_STRING;
                  end
                  KIND_NUMBER: begin
                     nx.mode      = MODE_NUMBER;
                     nx.num_minus = (text_byte == CH_MINUS);
                     nx.num_point = 1'b0;
                     nx.num_zero  = (text_byte == CH_ZERO);
                  end
                  KIND_TRUE, KIND_FALSE, KIND_NULL: begin
                     nx.mode   = MODE_KEYWORD;
                     nx.kw_pos = 3'd1;
                     if (gap_kind == KIND_TRUE) begin
                        nx.kw_kind = KW_TRUE;
                     end else if (gap_kind == KIND_FALSE) begin
                        nx.kw_kind = KW_FALSE;
                     end else begin
                        nx.kw_kind = KW_NULL;
                     end
                  end
                  default: begin
                  end
               endcase
               if (err == ERR_NONE) begin
                  kind      = gap_kind;
                  first     = 1'b1;
                  fin       = (gap_kind <= KIND_COLON);
                  nx.column = pos_inc(state.column);
               end
            end
         end

         // closing checks on the final byte
         if (err == ERR_NONE && end_of_text) begin
            if (nx.mode == MODE_STRING) begin
               err = ERR_OPEN_STRING;
            end else if (nx.mode == MODE_KEYWORD) begin
               err = ERR_BAD_KEYWORD;
            end else if (!nx.root_seen) begin
               err = ERR_BAD_START;
            end else if (nx.bracket_depth != '0) begin
               err = ERR_BRACKETS;
            end else if (nx.brace_depth != '0) begin
               err = ERR_BRACES;
            end
         end

         if (err != ERR_NONE) nx.error = err;
      end
   end

   // response fields, token flags masked once an error has stuck
   always_comb begin
      result.token_kind    = (nx.error == ERR_NONE) ? kind : KIND_BLANK;
      result.token_first   = (nx.error == ERR_NONE) && first;
      result.token_final   = (nx.error == ERR_NONE) && fin;
      result.number_closed = (nx.error == ERR_NONE) && nclosed;
      result.token_line    = nx.start_line;
      result.token_column  = nx.start_column;
      result.error_code    = nx.error;
      result.result_last   = end_of_text;
   end

   // the final byte of a text returns the scanner to its reset state
   assign state_next = end_of_text ? SCAN_RESET : nx;

endmodule

`default_nettype wire
